// File: hdl/gor_pkg.sv
// Package with the payload types and register indexes of the group order line reverser.
package gor_pkg;

	// Configuration port widths and register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_LINE_GROUPS  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LINES_IN_RUN = 2'd1;

	// Input command codes.
	localparam logic CMD_DATA  = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// One input item.
	typedef struct packed {
		logic        command;
		logic [63:0] data_word;
	} src_item_t;

	// One result item.
	typedef struct packed {
		logic [63:0] out_word;
		logic        line_end;
		logic        run_end;
	} dst_item_t;

endpackage

// File: hdl/gor_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module gor_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2056,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port; a read of the address written in the same cycle returns the old data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: hdl/group_order_line_reverser_top.sv
// Top level of the group order line reverser: control, slot store and output register.
//
// The block reverses the order of groups of GROUP_WORDS words inside each line of a
// stream of 64-bit words and keeps the word order inside each group.
// Channels: src (valid/ready, src_item carries command and data_word), dst
// (valid/ready, dst_item carries out_word, line_end and run_end) and cfg (valid/ready
// write channel, index 0 = line_groups, index 1 = lines_in_run, values saturate).
// cfg_ready is always high; write registers only between runs or between items.
// The first line of a run is loaded with no results. Each later data word returns
// one word of the previous line in reversed group order; after the last line, drain
// commands return the final line, the last word flagged with run_end.
// Throughput: one item per cycle unless dst stalls. The slot store has separate
// read and write ports; the read and write of one word always go to different slots.
// A result reaches dst through the registered store read and then the output
// register.
// A stalled receiver holds the output register; one more item can still enter and
// wait in the read stage, after which src_ready drops until the receiver takes one.
// Reset clears the control state and returns to loading with line_groups and
// lines_in_run at 1; the slot store is not cleared and needs no clearing pass.
module group_order_line_reverser_top #(
	parameter int GROUP_WORDS     = 8,
	parameter int MAX_LINE_GROUPS = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         src_valid,
	output logic                         src_ready,
	input  gor_pkg::src_item_t           src_item,
	output logic                         dst_valid,
	input  logic                         dst_ready,
	output gor_pkg::dst_item_t           dst_item,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [gor_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [gor_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int SLOT_COUNT = MAX_LINE_GROUPS + 1;
	localparam int DEPTH      = GROUP_WORDS * SLOT_COUNT;
	localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int GRP_W      = (MAX_LINE_GROUPS > 1) ? $clog2(MAX_LINE_GROUPS) : 1;
	localparam int WORD_W     = (GROUP_WORDS > 1) ? $clog2(GROUP_WORDS) : 1;
	localparam int LIR_W      = gor_pkg::CFG_DATA_W;

	typedef enum logic [2:0] {
		PH_LOAD   = 3'b001,
		PH_STREAM = 3'b010,
		PH_DRAIN  = 3'b100
	} phase_t;

	// Control state.
	phase_t              phase_q, phase_d;
	logic [SLOT_W-1:0]   read_slot_q, read_slot_d;
	logic                going_up_q, going_up_d;
	logic [WORD_W-1:0]   word_q, word_d;
	logic [GRP_W-1:0]    group_q, group_d;
	logic [LIR_W-1:0]    line_count_q, line_count_d;
	logic [SLOT_W-1:0]   line_groups_q;
	logic [LIR_W-1:0]    lines_in_run_q;

	// Read stage and output register.
	logic                s1_valid_s1;
	logic                line_end_s1, run_end_s1;
	logic                line_end_d, run_end_d;
	logic                out_valid_q;
	gor_pkg::dst_item_t  out_item_q;

	// Handshake and store access.
	logic                s1_move, accept, produce, load_write;
	logic                group_done, line_last;
	logic [SLOT_W-1:0]   nb_slot;
	logic [LIR_W-1:0]    line_count_inc;
	logic                ram_wr_en, ram_rd_en;
	logic [ADDR_W-1:0]   ram_wr_addr, ram_rd_addr;
	logic [63:0]         ram_rd_data;

	// Flat store address of one word of one slot.
	function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] slot,
			input logic [WORD_W-1:0] word);
		slot_addr = ADDR_W'(slot) * ADDR_W'(GROUP_WORDS) + ADDR_W'(word);
	endfunction

	// Pipeline flow: the read stage moves on when the output register is free or drains.
	assign s1_move   = s1_valid_s1 && (!out_valid_q || dst_ready);
	assign src_ready = !s1_valid_s1 || s1_move;
	assign accept    = src_valid && src_ready;
	assign produce   = accept && (((phase_q == PH_STREAM) && (src_item.command == gor_pkg::CMD_DATA))
		|| ((phase_q == PH_DRAIN) && (src_item.command == gor_pkg::CMD_DRAIN)));
	assign load_write = accept && (phase_q == PH_LOAD) && (src_item.command == gor_pkg::CMD_DATA);

	// Neighboring slot that takes the incoming word while streaming.
	always_comb begin
		if (going_up_q) begin
			nb_slot = (read_slot_q == '0) ? SLOT_W'(MAX_LINE_GROUPS) : read_slot_q - 1'b1;
		end else begin
			nb_slot = (read_slot_q == SLOT_W'(MAX_LINE_GROUPS)) ? '0 : read_slot_q + 1'b1;
		end
	end

	// Store ports.
	assign ram_rd_en   = produce;
	assign ram_rd_addr = slot_addr(read_slot_q, word_q);
	assign ram_wr_en   = load_write || (produce && (phase_q == PH_STREAM));
	assign ram_wr_addr = (phase_q == PH_LOAD) ? slot_addr(SLOT_W'(group_q), word_q)
		: slot_addr(nb_slot, word_q);

	assign group_done     = (word_q == WORD_W'(GROUP_WORDS - 1));
	assign line_last      = ({1'b0, SLOT_W'(group_q)} + 1'b1) >= {1'b0, line_groups_q};
	assign line_count_inc = line_count_q + 1'b1;

	// Next state of the line walk.
	always_comb begin
		phase_d      = phase_q;
		read_slot_d  = read_slot_q;
		going_up_d   = going_up_q;
		word_d       = word_q;
		group_d      = group_q;
		line_count_d = line_count_q;
		line_end_d   = 1'b0;
		run_end_d    = 1'b0;
		if (load_write || produce) begin
			word_d = group_done ? '0 : word_q + 1'b1;
		end
		unique case (phase_q)
			PH_LOAD: begin
				if (load_write && group_done) begin
					if (line_last) begin
						group_d      = '0;
						read_slot_d  = line_groups_q - 1'b1;
						going_up_d   = 1'b0;
						line_count_d = '0;
						phase_d      = (lines_in_run_q <= LIR_W'(1)) ? PH_DRAIN : PH_STREAM;
					end else begin
						group_d = group_q + 1'b1;
					end
				end
			end
			PH_STREAM, PH_DRAIN: begin
				if (produce && group_done) begin
					// Step the read slot and flip direction at either end.
					if (going_up_q) begin
						if (read_slot_q >= line_groups_q) begin
							read_slot_d = line_groups_q - 1'b1;
							going_up_d  = 1'b0;
						end else begin
							read_slot_d = read_slot_q + 1'b1;
						end
					end else begin
						if (read_slot_q == '0) begin
							read_slot_d = SLOT_W'(1);
							going_up_d  = 1'b1;
						end else begin
							read_slot_d = read_slot_q - 1'b1;
						end
					end
					if (line_last) begin
						group_d    = '0;
						line_end_d = 1'b1;
						if (phase_q == PH_DRAIN) begin
							run_end_d    = 1'b1;
							phase_d      = PH_LOAD;
							read_slot_d  = '0;
							going_up_d   = 1'b0;
							word_d       = '0;
							line_count_d = '0;
						end else begin
							line_count_d = line_count_inc;
							if (({1'b0, line_count_inc} + 1'b1) >= {1'b0, lines_in_run_q}) begin
								phase_d = PH_DRAIN;
							end
						end
					end else begin
						group_d = group_q + 1'b1;
					end
				end
			end
			default: begin
				phase_d = PH_LOAD;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_LOAD;
			read_slot_q  <= '0;
			going_up_q   <= 1'b0;
			word_q       <= '0;
			group_q      <= '0;
			line_count_q <= '0;
		end else begin
			phase_q      <= phase_d;
			read_slot_q  <= read_slot_d;
			going_up_q   <= going_up_d;
			word_q       <= word_d;
			group_q      <= group_d;
			line_count_q <= line_count_d;
		end
	end

	// Configuration registers with saturation to their legal ranges.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_groups_q  <= SLOT_W'(1);
			lines_in_run_q <= LIR_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				gor_pkg::CFG_LINE_GROUPS: begin
					if (cfg_data == '0) begin
						line_groups_q <= SLOT_W'(1);
					end else if (cfg_data > gor_pkg::CFG_DATA_W'(MAX_LINE_GROUPS)) begin
						line_groups_q <= SLOT_W'(MAX_LINE_GROUPS);
					end else begin
						line_groups_q <= SLOT_W'(cfg_data);
					end
				end
				gor_pkg::CFG_LINES_IN_RUN: begin
					lines_in_run_q <= (cfg_data == '0) ? LIR_W'(1) : cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Read stage: flags wait here while the store read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (produce) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_move) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			line_end_s1 <= line_end_d;
			run_end_s1  <= run_end_d;
		end
	end

	// Output register; it holds its transfer while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (dst_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_item_q.out_word <= ram_rd_data;
			out_item_q.line_end <= line_end_s1;
			out_item_q.run_end  <= run_end_s1;
		end
	end

	assign dst_valid = out_valid_q;
	assign dst_item  = out_item_q;

	// Slot store.
	gor_ram #(
		.WIDTH(64),
		.DEPTH(DEPTH)
	) u_slot_store (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(src_item.data_word),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

`ifndef SYNTHESIS
	// The read and the write of one cycle never hit the same store entry.
	a_no_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr_en && ram_rd_en |-> ram_wr_addr != ram_rd_addr)
		else $error("store read and write collide on one entry");

	// A full read stage behind a stalled output register blocks new input.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && out_valid_q && !dst_ready |-> !src_ready)
		else $error("input accepted while both stages are full and stalled");

	// A waiting read-stage item reaches the output register in the next cycle.
	a_stage_advances: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && (!out_valid_q || dst_ready) |=> out_valid_q)
		else $error("read stage item was lost");

	// The end of a run is always the end of a line.
	a_run_end_on_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_item.run_end |-> dst_item.line_end)
		else $error("run_end without line_end");

	// The read slot stays inside the slot store.
	a_read_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_LOAD |-> read_slot_q <= SLOT_W'(MAX_LINE_GROUPS))
		else $error("read slot outside the store");
`endif

endmodule
